>>> sv/rational_add_reduce_top_defines.svh
// Assertion macros for the rational add/reduce block
`ifndef RATIONAL_ADD_REDUCE_TOP_DEFINES_SVH
`define RATIONAL_ADD_REDUCE_TOP_DEFINES_SVH
`define RAR_ASSERT_IMP(label, clk, rst, a, c, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) else $error(msg);
`define RAR_ASSERT_NEXT(label, clk, rst, a, c, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) else $error(msg);
`endif

>>> sv/rar_pkg.sv
// Package: widths and sequencer states for the rational add/reduce block
package rar_pkg;
  localparam int VALUE_BITS = 16;
  localparam int DEN_BITS   = VALUE_BITS - 1;
  localparam int PROD_BITS  = 2 * VALUE_BITS;
  localparam int MAG_BITS   = PROD_BITS + 1;
  localparam int CNT_BITS   = $clog2(MAG_BITS + 1);
  localparam int OUT_NUM_BITS = 32;
  localparam int OUT_DEN_BITS = 30;

  typedef enum logic [3:0] {
    ST_IDLE, ST_MUL1, ST_MUL2, ST_MUL3, ST_SUM,
    ST_GCD, ST_GCD_WAIT, ST_QN, ST_QN_WAIT, ST_QD, ST_QD_WAIT, ST_DONE
  } state_t;

  typedef struct packed {
    logic start;
    logic busy;
    logic done;
  } div_ctl_t;
endpackage

>>> sv/rar_div.sv
// Shared restoring divider: one quotient bit per cycle
module rar_div (
  input  logic clk,
  input  logic rst,
  input  logic start,
  input  logic [rar_pkg::MAG_BITS-1:0] dividend,
  input  logic [rar_pkg::MAG_BITS-1:0] divisor,
  output rar_pkg::div_ctl_t ctl,
  output logic [rar_pkg::MAG_BITS-1:0] quot,
  output logic [rar_pkg::MAG_BITS-1:0] rem
);
  import rar_pkg::*;
  `include "rational_add_reduce_top_defines.svh"

  logic [MAG_BITS-1:0] dvs;
  logic [CNT_BITS-1:0] cnt;
  logic busy;
  logic done;
  logic [MAG_BITS:0] trial;
  logic [MAG_BITS:0] shifted;

  assign shifted = {rem, quot[MAG_BITS-1]};
  assign trial = shifted - {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt <= '0;
    end else begin
      done <= 1'b0;
      if (start && !busy) begin
        busy <= 1'b1;
        cnt <= CNT_BITS'(MAG_BITS);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == CNT_BITS'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start && !busy) begin
      quot <= dividend;
      rem <= '0;
      dvs <= divisor;
    end else if (busy) begin
      if (!trial[MAG_BITS]) begin
        rem <= trial[MAG_BITS-1:0];
        quot <= {quot[MAG_BITS-2:0], 1'b1};
      end else begin
        rem <= shifted[MAG_BITS-1:0];
        quot <= {quot[MAG_BITS-2:0], 1'b0};
      end
    end
  end

  assign ctl = '{start: start, busy: busy, done: done};

  `RAR_ASSERT_NEXT(a_div_done_pulse, clk, rst, done, !done, "divider done held")
  `RAR_ASSERT_IMP(a_div_done_idle, clk, rst, done, !busy, "divider done while busy")
endmodule

>>> sv/rational_add_reduce_top.sv
// Top level: fraction sum reduced by Euclid's GCD on a shared divider
//   channel | ports                          | handshake
//   in      | num_a den_a num_b den_b        | start && !busy
//   out     | sum_num sum_den                | done (one cycle)
// After the accepting edge the sequencer runs MUL1, MUL2, MUL3 and SUM, then k Euclid
// steps, each a pass of the shared 33-bit bit-serial divider, and two more passes to
// form the quotients, before done. A zero sum goes from SUM straight to DONE.
// rst is synchronous and clears the sequencer. The receiver cannot stall; busy is
// high until the done cycle has passed.
module rational_add_reduce_top (
  input  logic clk,
  input  logic rst,
  input  logic start,
  output logic busy,
  input  logic signed [rar_pkg::VALUE_BITS-1:0] num_a,
  input  logic [rar_pkg::DEN_BITS-1:0] den_a,
  input  logic signed [rar_pkg::VALUE_BITS-1:0] num_b,
  input  logic [rar_pkg::DEN_BITS-1:0] den_b,
  output logic done,
  output logic signed [rar_pkg::OUT_NUM_BITS-1:0] sum_num,
  output logic [rar_pkg::OUT_DEN_BITS-1:0] sum_den
);
  import rar_pkg::*;
  `include "rational_add_reduce_top_defines.svh"

  state_t state, state_next;
  logic signed [VALUE_BITS-1:0] a, c;
  logic [DEN_BITS-1:0] b, d;
  logic signed [PROD_BITS:0] p1, top;
  logic [PROD_BITS-1:0] bottom;
  logic [MAG_BITS-1:0] mag, x, y, g;
  logic neg;
  logic [MAG_BITS-1:0] div_a, div_b, quot, rem;
  logic div_start;
  div_ctl_t dctl;
  logic signed [VALUE_BITS:0] mul_l;
  logic signed [VALUE_BITS:0] mul_r;
  logic signed [PROD_BITS+1:0] mul_p;

  always_comb begin
    unique case (state)
      ST_MUL1: begin
        mul_l = {a[VALUE_BITS-1], a};
        mul_r = {2'b00, d};
      end
      ST_MUL2: begin
        mul_l = {c[VALUE_BITS-1], c};
        mul_r = {2'b00, b};
      end
      default: begin
        mul_l = {2'b00, b};
        mul_r = {2'b00, d};
      end
    endcase
  end
  assign mul_p = mul_l * mul_r;

  rar_div u_div (
    .clk(clk), .rst(rst), .start(div_start), .dividend(div_a), .divisor(div_b),
    .ctl(dctl), .quot(quot), .rem(rem)
  );

  always_comb begin
    state_next = state;
    div_start = 1'b0;
    div_a = x;
    div_b = y;
    unique case (state)
      ST_IDLE: if (start && !busy) state_next = ST_MUL1;
      ST_MUL1: state_next = ST_MUL2;
      ST_MUL2: state_next = ST_MUL3;
      ST_MUL3: state_next = ST_SUM;
      ST_SUM: state_next = (top == '0) ? ST_DONE : ST_GCD;
      ST_GCD: begin
        if (y == '0) begin
          state_next = ST_QN;
        end else begin
          div_start = 1'b1;
          state_next = ST_GCD_WAIT;
        end
      end
      ST_GCD_WAIT: if (dctl.done) state_next = ST_GCD;
      ST_QN: begin
        div_a = mag;
        div_b = g;
        div_start = 1'b1;
        state_next = ST_QN_WAIT;
      end
      ST_QN_WAIT: if (dctl.done) state_next = ST_QD;
      ST_QD: begin
        div_a = {1'b0, bottom};
        div_b = g;
        div_start = 1'b1;
        state_next = ST_QD_WAIT;
      end
      ST_QD_WAIT: if (dctl.done) state_next = ST_DONE;
      ST_DONE: state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      done <= 1'b0;
    end else begin
      state <= state_next;
      done <= (state == ST_DONE);
    end
  end

  always_ff @(posedge clk) begin
    unique case (state)
      ST_IDLE: if (start && !busy) begin
        a <= num_a;
        c <= num_b;
        b <= (den_a == '0) ? DEN_BITS'(1) : den_a;
        d <= (den_b == '0) ? DEN_BITS'(1) : den_b;
      end
      ST_MUL1: p1 <= mul_p[PROD_BITS:0];
      ST_MUL2: top <= p1 + mul_p[PROD_BITS:0];
      ST_MUL3: bottom <= mul_p[PROD_BITS-1:0];
      ST_SUM: begin
        neg <= top[PROD_BITS];
        mag <= top[PROD_BITS] ? MAG_BITS'(-top) : MAG_BITS'(top);
        x <= top[PROD_BITS] ? MAG_BITS'(-top) : MAG_BITS'(top);
        y <= {1'b0, bottom};
        if (top == '0) begin
          sum_num <= '0;
          sum_den <= OUT_DEN_BITS'(1);
        end
      end
      ST_GCD: if (y == '0) g <= x;
      ST_GCD_WAIT: if (dctl.done) begin
        x <= y;
        y <= rem;
      end
      ST_QN_WAIT: if (dctl.done)
        sum_num <= neg ? OUT_NUM_BITS'(-quot) : OUT_NUM_BITS'(quot);
      ST_QD_WAIT: if (dctl.done) sum_den <= OUT_DEN_BITS'(quot);
      default: ;
    endcase
  end

  assign busy = (state != ST_IDLE) || done;

  `RAR_ASSERT_NEXT(a_done_pulse, clk, rst, done, !done, "done held two cycles")
  `RAR_ASSERT_IMP(a_div_quiet, clk, rst, state == ST_IDLE, !dctl.busy, "divider busy while idle")
  `RAR_ASSERT_IMP(a_den_nonzero, clk, rst, done, sum_den != '0, "zero denominator")
endmodule
